// File: hdl/rmsn_pkg.sv
// Package for the RMS row normalizer: widths, constants and shared types.
// No dependencies; used by every module in hdl.
package rmsn_pkg;
	localparam int DATA_W   = 16;
	localparam int EPS_W    = 24;
	localparam int SUM_W    = 40;
	localparam int INV_W    = 31;
	localparam int ROW_MAX_DEFAULT = 64;
	localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // write element, accumulate square
		logic div_start; // start sum/count divide
		logic sqrt_start;// start 2^60/v divide then root (chained inside)
		logic rd_en;     // read buffer entry, product pipeline valid
	} rmsn_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
	} rmsn_sts_t;
endpackage

// File: hdl/rms_row_normalizer_top.sv
// RMS row normalizer: each row element is buffered and its square summed;
// at row end inv = 1/sqrt(sum/n + epsilon) is found with a bit-serial
// 64-step divider (run twice) and a 32-step root; then each element in turn
// passes buffer read, two multiply stages and output register, the next read
// waiting for the last result. Elements load at one per cycle in the load phase.
// Depends on rmsn_pkg, rmsn_ctrl, rmsn_datapath.
module rms_row_normalizer_top #(
	parameter int ROW_MAX = rmsn_pkg::ROW_MAX_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rmsn_pkg::EPS_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // sample[15:0], weight[31:16]
	input  logic                       s_tlast,  // row_end
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,  // normalized
	output logic                       m_tuser,  // clipped
	output logic                       m_tlast   // final_of_row
);
	import rmsn_pkg::*;
	localparam int IDX_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

	logic [EPS_W-1:0] eps_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eps_q <= EPS_RESET;
		else if (cfg_we) eps_q <= cfg_wdata;
	end

	rmsn_cmd_t cmd;
	rmsn_sts_t sts;
	logic [IDX_W-1:0] wr_idx, rd_idx;
	logic [IDX_W:0] count;
	logic clear_sum, res_clip, res_vld;
	logic [15:0] res_val;
	logic [17:0] out_data;

	rmsn_ctrl #(.ROW_MAX(ROW_MAX), .IDX_W(IDX_W)) u_ctrl (
		.clk, .arst_n, .in_vld(s_tvalid), .in_last(s_tlast), .in_rdy(s_tready),
		.cmd, .sts, .wr_idx, .rd_idx, .count, .clear_sum,
		.res_val, .res_clip, .res_vld, .out_data, .out_vld(m_tvalid),
		.out_rdy(m_tready));

	rmsn_datapath #(.ROW_MAX(ROW_MAX), .IDX_W(IDX_W)) u_dp (
		.clk, .arst_n, .cmd, .sts, .wr_idx, .rd_idx, .count, .epsilon(eps_q),
		.sample(s_tdata[15:0]), .weight(s_tdata[31:16]), .clear_sum,
		.res_val, .res_clip, .res_vld);

	assign m_tdata = out_data[15:0];
	assign m_tuser = out_data[16];
	assign m_tlast = out_data[17];
endmodule

// File: hdl/rmsn_datapath.sv
// Datapath of the RMS row normalizer: buffers, square sum, divider, square
// root, product pipeline. Depends on rmsn_pkg.
module rmsn_datapath #(
	parameter int ROW_MAX = rmsn_pkg::ROW_MAX_DEFAULT,
	parameter int IDX_W   = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmsn_pkg::rmsn_cmd_t          cmd,
	output rmsn_pkg::rmsn_sts_t          sts,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [IDX_W-1:0]             rd_idx,
	input  logic [IDX_W:0]               count,
	input  logic [rmsn_pkg::EPS_W-1:0]   epsilon,
	input  logic signed [15:0]           sample,
	input  logic signed [15:0]           weight,
	input  logic                         clear_sum,
	output logic [15:0]                  res_val,
	output logic                         res_clip,
	output logic                         res_vld
);
	import rmsn_pkg::*;

	logic [15:0] smem [ROW_MAX];
	logic [15:0] wmem [ROW_MAX];
	logic [SUM_W-1:0] sum_q;
	logic signed [15:0] s_rd_s1, w_rd_s1;
	logic vld_s1, vld_s2, vld_s3;

	// buffers, registered read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smem[wr_idx] <= sample;
			wmem[wr_idx] <= weight;
		end
		s_rd_s1 <= smem[rd_idx];
		w_rd_s1 <= wmem[rd_idx];
	end

	// square accumulator
	logic [31:0] sq;
	assign sq = 32'(sample * sample);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear_sum) begin
			sum_q <= '0;
		end else if (cmd.load) begin
			sum_q <= sum_q + SUM_W'(sq);
		end
	end

	// shared restoring divider: 64-bit dividend, one quotient bit a cycle
	localparam int DV_W = 64;
	logic [DV_W-1:0] dnd_q, quo_q;
	logic [DV_W:0]   rem_q;
	logic [DV_W-1:0] dsr_q;
	logic [6:0]      dcnt_q;
	logic            dbusy_q, dphase_q; // phase 0: mean, 1: 2^60/v
	logic [DV_W:0]   rem_sh;
	logic [DV_W:0]   rem_sub;
	assign rem_sh  = {rem_q[DV_W-1:0], dnd_q[DV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	// square root, bit-serial, started when the second divide ends
	logic [63:0] sx_q, sres_q, sbit_q;
	logic        sbusy_q, sdone_q, ddone_q;
	logic [63:0] vsum;
	logic [INV_W-1:0] inv_q;
	assign vsum = sres_q + sbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0; dphase_q <= 1'b0; dcnt_q <= '0;
			sbusy_q <= 1'b0; sdone_q <= 1'b0; ddone_q <= 1'b0;
			dnd_q <= '0; quo_q <= '0; rem_q <= '0; dsr_q <= '0;
			sx_q <= '0; sres_q <= '0; sbit_q <= '0; inv_q <= '0;
		end else begin
			// one-cycle done pulses
			ddone_q <= dbusy_q && (dcnt_q == 7'd1) && !dphase_q;
			sdone_q <= sbusy_q && (sbit_q == '0);
			if (cmd.div_start) begin
				dnd_q <= DV_W'(sum_q); rem_q <= '0; quo_q <= '0;
				dsr_q <= DV_W'(count); dcnt_q <= 7'd64;
				dbusy_q <= 1'b1; dphase_q <= 1'b0;
			end else if (cmd.sqrt_start) begin
				// v = mean + eps, zero taken as one
				if (quo_q + DV_W'(epsilon) == '0) dsr_q <= DV_W'(1);
				else dsr_q <= quo_q + DV_W'(epsilon);
				dnd_q <= 64'h1000_0000_0000_0000; rem_q <= '0; quo_q <= '0;
				dcnt_q <= 7'd64; dbusy_q <= 1'b1; dphase_q <= 1'b1;
			end else if (dbusy_q) begin
				dnd_q <= {dnd_q[DV_W-2:0], 1'b0};
				if (!rem_sub[DV_W]) begin
					rem_q <= rem_sub; quo_q <= {quo_q[DV_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh; quo_q <= {quo_q[DV_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) begin
					dbusy_q <= 1'b0;
					if (dphase_q) begin
						sbusy_q <= 1'b1; sres_q <= '0;
						sbit_q <= 64'h4000_0000_0000_0000;
						sx_q <= rem_sub[DV_W] ? {quo_q[DV_W-2:0], 1'b0}
						                      : {quo_q[DV_W-2:0], 1'b1};
					end
				end
			end
			if (sbusy_q) begin
				if (sbit_q == '0) begin
					sbusy_q <= 1'b0; inv_q <= sres_q[INV_W-1:0];
				end else begin
					if (sx_q >= vsum) begin
						sx_q <= sx_q - vsum; sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
			end
		end
	end
	assign sts.div_done  = ddone_q;
	assign sts.sqrt_done = sdone_q;

	// product pipeline: s*w, then magnitude*inv, then round and saturate
	logic signed [31:0] p_s2;
	logic [62:0] m_s3;
	logic        neg_s3;
	logic [31:0] mag;
	assign mag = p_s2[31] ? 32'(-p_s2) : 32'(p_s2);
	always_ff @(posedge clk) begin
		p_s2   <= s_rd_s1 * w_rd_s1;
		m_s3   <= 63'(mag) * 63'(inv_q) + 63'(64'd1 << 29);
		neg_s3 <= p_s2[31];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
		end
	end
	logic [32:0] r;
	assign r = m_s3[62:30];
	always_comb begin
		res_clip = 1'b0;
		if (neg_s3) begin
			if (r > 33'd32768) begin res_val = 16'h8000; res_clip = 1'b1; end
			else res_val = 16'(17'h10000 - 17'(r));
		end else begin
			if (r > 33'd32767) begin res_val = 16'h7fff; res_clip = 1'b1; end
			else res_val = r[15:0];
		end
	end
	assign res_vld = vld_s3;

`ifndef SYNTHESIS
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(dbusy_q && sbusy_q)) else $error("divider and root overlap");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		sdone_q |-> $past(sbusy_q)) else $error("root done without work");
	a_vld: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> $past(cmd.rd_en, 3)) else $error("stray result");
`endif
endmodule

// File: hdl/rmsn_ctrl.sv
// Controller of the RMS row normalizer: load, reduce, emit sequence and
// output register. Depends on rmsn_pkg.
module rmsn_ctrl #(
	parameter int ROW_MAX = rmsn_pkg::ROW_MAX_DEFAULT,
	parameter int IDX_W   = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic                in_last,
	output logic                in_rdy,
	output rmsn_pkg::rmsn_cmd_t cmd,
	input  rmsn_pkg::rmsn_sts_t sts,
	output logic [IDX_W-1:0]    wr_idx,
	output logic [IDX_W-1:0]    rd_idx,
	output logic [IDX_W:0]      count,
	output logic                clear_sum,
	input  logic [15:0]         res_val,
	input  logic                res_clip,
	input  logic                res_vld,
	output logic [17:0]         out_data,
	output logic                out_vld,
	input  logic                out_rdy
);
	import rmsn_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;

	logic [2:0] state_q;
	logic [IDX_W:0] cnt_q, ridx_q;
	logic out_vld_q;
	logic [17:0] out_q;
	logic acc;
	logic row_close;
	logic div_go_q;
	logic pend_q;
	assign acc = in_vld && in_rdy;
	assign in_rdy = (state_q == ST_LOAD);
	assign wr_idx = cnt_q[IDX_W-1:0];
	assign rd_idx = ridx_q[IDX_W-1:0];
	assign count  = cnt_q;
	assign row_close = in_last || (cnt_q + 1'b1 == (IDX_W+1)'(ROW_MAX));

	always_comb begin
		cmd = '0;
		cmd.load = acc;
		cmd.div_start  = div_go_q;
		cmd.sqrt_start = (state_q == ST_MEAN) && sts.div_done;
		cmd.rd_en = (state_q == ST_RD);
	end
	// sum is no longer needed once the mean divide has taken it
	assign clear_sum = (state_q == ST_ROOT);

	// divide start pulse, first cycle of the mean phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_go_q <= 1'b0;
		else div_go_q <= acc && row_close;
	end

	// read in the product pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (cmd.rd_en) pend_q <= 1'b1;
		else if (res_vld) pend_q <= 1'b0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; cnt_q <= '0; ridx_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (acc) begin
					cnt_q <= cnt_q + 1'b1;
					if (row_close)
						state_q <= ST_MEAN;
				end
				ST_MEAN: if (sts.div_done) state_q <= ST_ROOT;
				ST_ROOT: if (sts.sqrt_done) begin state_q <= ST_RD; ridx_q <= '0; end
				ST_RD: begin
					ridx_q <= ridx_q + 1'b1;
					state_q <= ST_WAIT;
				end
				// result out of the pipeline and output register free or freeing
				ST_WAIT: if (!pend_q && !res_vld && (!out_vld_q || out_rdy)) begin
					if (ridx_q == cnt_q) begin state_q <= ST_LOAD; cnt_q <= '0; end
					else state_q <= ST_RD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (res_vld) out_vld_q <= 1'b1;
		else if (out_rdy) out_vld_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_vld) out_q <= {ridx_q == cnt_q, res_clip, res_val};
	end
	assign out_data = out_q;
	assign out_vld  = out_vld_q;

`ifndef SYNTHESIS
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !cmd.load) else $error("load outside load phase");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> !out_vld_q) else $error("output overwrite");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (IDX_W+1)'(ROW_MAX)) else $error("count overflow");
`endif
endmodule
